// ----- hw/rtl/hsb_to_rgb888_converter_macros.svh -----
// assertion helpers used by the converter rtl
`ifndef HSB_TO_RGB888_CONVERTER_MACROS_SVH
`define HSB_TO_RGB888_CONVERTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define HSB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HSB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/hsb2rgb_pkg.sv -----
package hsb2rgb_pkg;

  // fixed field widths
  localparam int unsigned HUE_W = 12;
  localparam int unsigned SAT_W = 13;
  localparam int unsigned BRI_W = 13;
  localparam int unsigned CH_W  = 8;

  // default fraction bits of the fixed-point format
  localparam int unsigned FRAC_BITS_DEF = 12;

  // hue sector codes
  localparam int unsigned SEC_W = 3;
  localparam logic [SEC_W-1:0] SEC_0 = 3'd0;
  localparam logic [SEC_W-1:0] SEC_1 = 3'd1;
  localparam logic [SEC_W-1:0] SEC_2 = 3'd2;
  localparam logic [SEC_W-1:0] SEC_3 = 3'd3;
  localparam logic [SEC_W-1:0] SEC_4 = 3'd4;
  localparam logic [SEC_W-1:0] SEC_5 = 3'd5;

  // level lanes
  localparam int unsigned NUM_LVL = 4;
  localparam int unsigned LVL_V   = 0;
  localparam int unsigned LVL_P   = 1;
  localparam int unsigned LVL_Q   = 2;
  localparam int unsigned LVL_T   = 3;

endpackage

// ----- hw/rtl/hsb_to_rgb888_converter.sv -----
// hsb to rgb888 conversion, three register stages
// an accepted input word passes through stage one, stage two and the output register in turn
// throughput: one word per cycle while the receiver does not stall
// stalls back up stage by stage; empty stages keep taking words
// reset (rst_ni low, asynchronous) empties all stages
module hsb_to_rgb888_converter #(
  parameter int unsigned FRAC_BITS = hsb2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [hsb2rgb_pkg::HUE_W-1:0] hue_i,
  input  logic [hsb2rgb_pkg::SAT_W-1:0] saturation_i,
  input  logic [hsb2rgb_pkg::BRI_W-1:0] brightness_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [hsb2rgb_pkg::CH_W-1:0]  red_o,
  output logic [hsb2rgb_pkg::CH_W-1:0]  green_o,
  output logic [hsb2rgb_pkg::CH_W-1:0]  blue_o
);
  import hsb2rgb_pkg::*;

`include "hsb_to_rgb888_converter_macros.svh"

  // widths of the fixed-point datapath
  localparam int unsigned LVL_W  = FRAC_BITS + 1;
  localparam int unsigned M_W    = 2 * FRAC_BITS + 1;
  localparam int unsigned P_W    = LVL_W + M_W;
  localparam int unsigned L_W    = P_W + CH_W;
  localparam int unsigned WIDE_W = HUE_W + 3 + FRAC_BITS;

  localparam logic [LVL_W-1:0] ONE  = LVL_W'(1) << FRAC_BITS;
  localparam logic [M_W-1:0]   ONE2 = M_W'(1) << (2 * FRAC_BITS);

  // pipeline control
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic adv1, adv2, adv3;

  assign adv3    = !out_valid_q || !stall_i;
  assign adv2    = !s2_valid_q || adv3;
  assign adv1    = !s1_valid_q || adv2;
  assign stall_o = !adv1;
  assign valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q  <= valid_i;
      if (adv2) s2_valid_q  <= s1_valid_q;
      if (adv3) out_valid_q <= s2_valid_q;
    end
  end

  // stage one: sector, fraction, clamping and the weights
  logic [WIDE_W-1:0]    hs_wide;
  logic [WIDE_W-1:0]    sec_raw;
  logic [FRAC_BITS-1:0] frac;
  logic [LVL_W-1:0]     frac_c, sat_c, bri_c;
  logic [SEC_W-1:0]     s1_sector_d;
  logic [M_W-1:0]       s1_m_d [NUM_LVL];

  always_comb begin
    hs_wide = (WIDE_W'(hue_i) << 2) + (WIDE_W'(hue_i) << 1);
    frac    = hs_wide[FRAC_BITS-1:0];
    sec_raw = hs_wide >> FRAC_BITS;
    s1_sector_d = (sec_raw <= WIDE_W'(SEC_5)) ? sec_raw[SEC_W-1:0] : SEC_0;
    sat_c  = (WIDE_W'(saturation_i) > WIDE_W'(ONE)) ? ONE : LVL_W'(saturation_i);
    bri_c  = (WIDE_W'(brightness_i) > WIDE_W'(ONE)) ? ONE : LVL_W'(brightness_i);
    frac_c = LVL_W'(frac);
    s1_m_d[LVL_V] = ONE2;
    s1_m_d[LVL_P] = M_W'(ONE - sat_c) << FRAC_BITS;
    s1_m_d[LVL_Q] = ONE2 - M_W'(M_W'(frac_c) * M_W'(sat_c));
    s1_m_d[LVL_T] = ONE2 - M_W'(M_W'(ONE - frac_c) * M_W'(sat_c));
  end

  logic [SEC_W-1:0] s1_sector_q;
  logic [LVL_W-1:0] s1_bri_q;
  logic [M_W-1:0]   s1_m_q [NUM_LVL];

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_sector_q <= s1_sector_d;
      s1_bri_q    <= bri_c;
      s1_m_q      <= s1_m_d;
    end
  end

  // stage two: brightness times weight, one multiplier per level
  logic [SEC_W-1:0] s2_sector_q;
  logic [P_W-1:0]   s2_prod_q [NUM_LVL];
  logic [P_W-1:0]   s2_prod_d [NUM_LVL];

  always_comb begin
    for (int i = 0; i < NUM_LVL; i++) begin
      s2_prod_d[i] = P_W'(s1_bri_q) * P_W'(s1_m_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_sector_q <= s1_sector_q;
      s2_prod_q   <= s2_prod_d;
    end
  end

  // stage three: scale by 255, drop the fraction, order the channels
  logic [L_W-1:0]  scaled [NUM_LVL];
  logic [CH_W-1:0] lvl    [NUM_LVL];
  logic [CH_W-1:0] red_d, green_d, blue_d;

  always_comb begin
    for (int i = 0; i < NUM_LVL; i++) begin
      scaled[i] = (L_W'(s2_prod_q[i]) << CH_W) - L_W'(s2_prod_q[i]);
      lvl[i]    = scaled[i][3*FRAC_BITS +: CH_W];
    end
    case (s2_sector_q)
      SEC_1: begin
        red_d = lvl[LVL_Q]; green_d = lvl[LVL_V]; blue_d = lvl[LVL_P];
      end
      SEC_2: begin
        red_d = lvl[LVL_P]; green_d = lvl[LVL_V]; blue_d = lvl[LVL_T];
      end
      SEC_3: begin
        red_d = lvl[LVL_P]; green_d = lvl[LVL_Q]; blue_d = lvl[LVL_V];
      end
      SEC_4: begin
        red_d = lvl[LVL_T]; green_d = lvl[LVL_P]; blue_d = lvl[LVL_V];
      end
      SEC_5: begin
        red_d = lvl[LVL_V]; green_d = lvl[LVL_P]; blue_d = lvl[LVL_Q];
      end
      default: begin
        red_d = lvl[LVL_V]; green_d = lvl[LVL_T]; blue_d = lvl[LVL_P];
      end
    endcase
  end

  logic [CH_W-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // checks on the pipeline control and the level ordering
  `HSB_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, stall_o, s1_valid_q && s2_valid_q && out_valid_q, "input stalled with a free stage")
  `HSB_ASSERT_NXT(a_accept_lands, clk_i, rst_ni, valid_i && !stall_o, s1_valid_q, "accepted word not in stage one")
  `HSB_ASSERT_NXT(a_s2_moves_out, clk_i, rst_ni, s2_valid_q && !stall_i, out_valid_q, "stage two word lost on its way out")
  `HSB_ASSERT_IMP(a_v_is_max, clk_i, rst_ni, s2_valid_q, (s2_prod_q[LVL_V] >= s2_prod_q[LVL_Q]) && (s2_prod_q[LVL_V] >= s2_prod_q[LVL_T]) && (s2_prod_q[LVL_V] >= s2_prod_q[LVL_P]), "brightness level below another level")

endmodule

// ----- dv/rgb_pixel_checker.sv -----
`timescale 1ns / 100ps

module rgb_pixel_checker #(
  parameter int unsigned FRAC_BITS = hsb2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [hsb2rgb_pkg::HUE_W-1:0] hue_i,
  input  logic [hsb2rgb_pkg::SAT_W-1:0] saturation_i,
  input  logic [hsb2rgb_pkg::BRI_W-1:0] brightness_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [hsb2rgb_pkg::CH_W-1:0]  red_i,
  input  logic [hsb2rgb_pkg::CH_W-1:0]  green_i,
  input  logic [hsb2rgb_pkg::CH_W-1:0]  blue_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import hsb2rgb_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_px_t;

  typedef longint unsigned u64_t;

  localparam u64_t UNIT = u64_t'(1) << FRAC_BITS;

  rgb_px_t expected_px[$];
  int      mismatches = 0;

  assign fail_count_o = mismatches;

  // floor(255 * b * w / unit^3), w being a weight scaled by unit^2
  function automatic u64_t channel_level(u64_t bri, u64_t weight);
    return (u64_t'(255) * bri * weight) >> (3 * FRAC_BITS);
  endfunction

  // expected rgb888 pixel for one hsb word
  function automatic rgb_px_t hsb_to_rgb(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                                          logic [BRI_W-1:0] bri);
    u64_t s, b, hs, sector, frac, v, p, q, t;
    rgb_px_t px;
    // values above one saturate at one
    s      = (u64_t'(sat) > UNIT) ? UNIT : u64_t'(sat);
    b      = (u64_t'(bri) > UNIT) ? UNIT : u64_t'(bri);
    hs     = u64_t'(hue) * 6;
    sector = hs >> FRAC_BITS;
    frac   = hs & (UNIT - 1);
    v      = channel_level(b, UNIT * UNIT);
    p      = channel_level(b, (UNIT - s) * UNIT);
    q      = channel_level(b, UNIT * UNIT - frac * s);
    t      = channel_level(b, UNIT * UNIT - (UNIT - frac) * s);
    // channel order per hue sector, anything past five takes sector zero order
    case (sector)
      u64_t'(SEC_1): px = '{red: q[CH_W-1:0], green: v[CH_W-1:0], blue: p[CH_W-1:0]};
      u64_t'(SEC_2): px = '{red: p[CH_W-1:0], green: v[CH_W-1:0], blue: t[CH_W-1:0]};
      u64_t'(SEC_3): px = '{red: p[CH_W-1:0], green: q[CH_W-1:0], blue: v[CH_W-1:0]};
      u64_t'(SEC_4): px = '{red: t[CH_W-1:0], green: p[CH_W-1:0], blue: v[CH_W-1:0]};
      u64_t'(SEC_5): px = '{red: v[CH_W-1:0], green: p[CH_W-1:0], blue: q[CH_W-1:0]};
      default:       px = '{red: v[CH_W-1:0], green: t[CH_W-1:0], blue: p[CH_W-1:0]};
    endcase
    return px;
  endfunction

  // watch both channels, queue predictions and compare output words in order
  always @(posedge clk_i) begin
    rgb_px_t exp_px;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        expected_px.push_back(hsb_to_rgb(hue_i, saturation_i, brightness_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_px.size() == 0) begin
          $error("output word with no pending prediction: r=%0d g=%0d b=%0d",
                 red_i, green_i, blue_i);
          mismatches++;
        end else begin
          exp_px = expected_px.pop_front();
          if (red_i !== exp_px.red) begin
            $error("red mismatch: expected %0d, actual %0d", exp_px.red, red_i);
            mismatches++;
          end
          if (green_i !== exp_px.green) begin
            $error("green mismatch: expected %0d, actual %0d", exp_px.green, green_i);
            mismatches++;
          end
          if (blue_i !== exp_px.blue) begin
            $error("blue mismatch: expected %0d, actual %0d", exp_px.blue, blue_i);
            mismatches++;
          end
        end
      end
    end
    pending_o <= expected_px.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import hsb2rgb_pkg::*;

  localparam int unsigned NUM_RANDOM = 1950;
  localparam int unsigned HOLD_AT    = 600;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned DRAIN_WAIT = 12;
  localparam logic [SAT_W-1:0] UNIT_LVL = 13'd4096;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             valid_i      = 1'b0;
  logic             stall_o;
  logic [HUE_W-1:0] hue_i        = '0;
  logic [SAT_W-1:0] saturation_i = '0;
  logic [BRI_W-1:0] brightness_i = '0;
  logic             valid_o;
  logic             stall_i      = 1'b0;
  logic [CH_W-1:0]  red_o;
  logic [CH_W-1:0]  green_o;
  logic [CH_W-1:0]  blue_o;

  int fail_count;
  int pending;
  int burst_left = 0;

  always #5 clk_i = ~clk_i;

  hsb_to_rgb888_converter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  rgb_pixel_checker px_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid_i),
    .in_stall_i   (stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_i  (valid_o),
    .out_stall_i  (stall_i),
    .red_i        (red_o),
    .green_i      (green_o),
    .blue_i       (blue_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // offer one hsb word and hold it until taken
  task automatic send_word(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                           logic [BRI_W-1:0] bri);
    hue_i        <= hue;
    saturation_i <= sat;
    brightness_i <= bri;
    valid_i      <= 1'b1;
    do @(posedge clk_i); while (stall_o);
  endtask

  // sender idle time: back-to-back bursts, short gaps, a few long ones
  task automatic sender_gap();
    int k;
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      k = $urandom_range(0, 99);
      if (k < 15) begin
        burst_left = $urandom_range(10, 60);
      end else if (k < 55) begin
        gap = 0;
      end else if (k < 90) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 40);
      end
    end
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // saturation or brightness: mostly in range, some edges, some above one
  function automatic logic [SAT_W-1:0] pick_level();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return SAT_W'($urandom_range(0, 4096));
    if (k < 80) return ($urandom_range(0, 1) != 0) ? UNIT_LVL : '0;
    if (k < 85) return ($urandom_range(0, 1) != 0) ? SAT_W'(UNIT_LVL + 1) : SAT_W'(UNIT_LVL - 1);
    return SAT_W'($urandom_range(0, 8191));
  endfunction

  // reset, then directed and random words
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners: black, white, gray, full color at the hue ends
    send_word(12'd0, 13'd0, 13'd0);
    send_word(12'd0, 13'd0, UNIT_LVL);
    send_word(12'd0, UNIT_LVL, UNIT_LVL);
    send_word(12'd4095, UNIT_LVL, UNIT_LVL);
    send_word(12'd4095, 13'd0, 13'd2048);
    // sector boundaries, just below and just above
    send_word(12'd682, UNIT_LVL, UNIT_LVL);
    send_word(12'd683, UNIT_LVL, UNIT_LVL);
    send_word(12'd1365, UNIT_LVL, UNIT_LVL);
    send_word(12'd1366, UNIT_LVL, UNIT_LVL);
    send_word(12'd2047, 13'd2048, UNIT_LVL);
    send_word(12'd2048, 13'd2048, UNIT_LVL);
    send_word(12'd2730, 13'd3000, 13'd3500);
    send_word(12'd2731, 13'd3000, 13'd3500);
    send_word(12'd3413, 13'd1000, 13'd4000);
    send_word(12'd3414, 13'd1000, 13'd4000);
    // saturation and brightness above one clamp to one; then values just below one and near zero
    send_word(12'd500, 13'd8191, 13'd8191);
    send_word(12'd1800, SAT_W'(UNIT_LVL + 1), BRI_W'(UNIT_LVL + 1));
    send_word(12'd2500, 13'd8191, 13'd1234);
    send_word(12'd3900, 13'd777, 13'd8191);
    send_word(12'd4095, 13'd8191, 13'd8191);
    send_word(12'd1000, SAT_W'(UNIT_LVL - 1), BRI_W'(UNIT_LVL - 1));
    send_word(12'd3000, 13'd1, 13'd1);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      sender_gap();
      send_word(HUE_W'($urandom_range(0, 4095)), pick_level(), pick_level());
    end
    valid_i <= 1'b0;

    // let the count of pending words catch up with the last accepted word
    @(posedge clk_i);

    // drain, then give stray words a chance to show up
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver stalls, with one long hold so the pipe backs up into the input
  initial begin
    int k;
    int n;
    int cycles;
    bit held;
    cycles = 0;
    held   = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      k = $urandom_range(0, 99);
      if (!held && cycles >= HOLD_AT) begin
        held    = 1'b1;
        n       = HOLD_LEN;
        stall_i <= 1'b1;
      end else if (k < 45) begin
        n       = $urandom_range(1, 25);
        stall_i <= 1'b0;
      end else if (k < 92) begin
        n       = $urandom_range(1, 3);
        stall_i <= 1'b1;
      end else begin
        n       = $urandom_range(10, 40);
        stall_i <= 1'b1;
      end
      repeat (n) @(posedge clk_i);
      cycles += n;
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- hsb_to_rgb888_converter.f -----
+incdir+hw/rtl
hw/rtl/hsb2rgb_pkg.sv
hw/rtl/hsb_to_rgb888_converter.sv
dv/rgb_pixel_checker.sv
dv/testbench.sv
